@@ sv/kpad_pkg.sv @@
// Shared types and constants for the keypad scan to key code unit.
`timescale 1ns / 1ps
`default_nettype none
package kpad_pkg;

  localparam int KEYMAP_DEPTH = 64;
  localparam int ENTRY_W = 32;
  localparam int CODE_W = 8;
  localparam int CNT_W = 7;
  localparam int MAP_W = 64;
  localparam logic [CODE_W-1:0] NO_CODE = 8'hFF;

  typedef enum logic [1:0] {
    SET_PLAIN,
    SET_SHIFT,
    SET_ALT,
    SET_CTRL
  } kpad_set_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_CLEAR,
    CMD_SCAN
  } kpad_kind_t;

  typedef enum logic [3:0] {
    REG_SHIFT_ROW,
    REG_SHIFT_COL,
    REG_ALT_ROW,
    REG_ALT_COL,
    REG_CTRL_ROW,
    REG_CTRL_COL,
    REG_REPEAT_FIRST,
    REG_REPEAT_NEXT
  } kpad_reg_t;

  typedef struct packed {
    kpad_kind_t        kind;
    kpad_set_t         set;
    logic [MAP_W-1:0]  map;
    logic [5:0]        index;
    logic [ENTRY_W-1:0] data;
  } kpad_cmd_t;

  typedef struct packed {
    logic [3:0]       shift_row;
    logic [3:0]       shift_col;
    logic [3:0]       alt_row;
    logic [3:0]       alt_col;
    logic [3:0]       ctrl_row;
    logic [3:0]       ctrl_col;
    logic [CNT_W-1:0] repeat_first;
    logic [CNT_W-1:0] repeat_next;
  } kpad_cfg_t;

endpackage
`default_nettype wire

@@ sv/keypad_scan_to_keycode_autorepeat_unit.sv @@
// Top level of the keypad scan to key code unit with autorepeat.
//
// Input channel (item_valid / item_stall): one item is either a keymap load
// (cmd low) or a scan report (cmd high). Output channel (key_valid /
// key_stall): one item per emitted key code; last_of_scan marks the final
// code of a scan. Configuration writes arrive on cfg_valid / cfg_ready with
// a register index and data; cfg_ready is always high.
// The front end classifies each item in the cycle it is accepted and pushes
// it into a two-entry queue. The back end takes a load or a clear in its
// idle state. A scan walks all 64 matrix positions through the keymap RAM
// read port, one position per cycle while the output is not stalled, and
// holds the back end until the walk ends and the last code is flushed. Each
// code waits in a pending register until the next code of the scan is found
// or the walk ends, so it passes the RAM read, pending and output registers.
// The last code of a scan is held until the walk ends so it can be marked.
// A stalled output freezes the walk; the queue then fills and item_stall
// rises. Reset restores the register defaults, marks every keymap entry
// as empty and clears the autorepeat state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module keypad_scan_to_keycode_autorepeat_unit import kpad_pkg::*; #(
  parameter int MATRIX_ROWS = 8,
  parameter int MATRIX_COLS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        cmd,
  input  wire logic [4:0]  key_count,
  input  wire logic [2:0]  single_row,
  input  wire logic [2:0]  single_col,
  input  wire logic [63:0] pressed_map,
  input  wire logic [5:0]  entry_index,
  input  wire logic [7:0]  code_plain,
  input  wire logic [7:0]  code_shift,
  input  wire logic [7:0]  code_alt,
  input  wire logic [7:0]  code_ctrl,
  output logic             key_valid,
  input  wire logic        key_stall,
  output logic [7:0]       key_code,
  output logic             last_of_scan,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  kpad_cfg_t cfg;
  logic      q_push;
  kpad_cmd_t q_in;
  logic      q_full;
  logic      q_pop;
  kpad_cmd_t q_out;
  logic      q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_row <= 4'd15;
      cfg.shift_col <= 4'd15;
      cfg.alt_row <= 4'd15;
      cfg.alt_col <= 4'd15;
      cfg.ctrl_row <= 4'd15;
      cfg.ctrl_col <= 4'd15;
      cfg.repeat_first <= 7'd12;
      cfg.repeat_next <= 7'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHIFT_ROW:    cfg.shift_row <= cfg_data[3:0];
        REG_SHIFT_COL:    cfg.shift_col <= cfg_data[3:0];
        REG_ALT_ROW:      cfg.alt_row <= cfg_data[3:0];
        REG_ALT_COL:      cfg.alt_col <= cfg_data[3:0];
        REG_CTRL_ROW:     cfg.ctrl_row <= cfg_data[3:0];
        REG_CTRL_COL:     cfg.ctrl_col <= cfg_data[3:0];
        REG_REPEAT_FIRST: cfg.repeat_first <= cfg_data;
        REG_REPEAT_NEXT:  cfg.repeat_next <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  kpad_front #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .MATRIX_COLS(MATRIX_COLS)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .key_count  (key_count),
    .single_row (single_row),
    .single_col (single_col),
    .pressed_map(pressed_map),
    .entry_index(entry_index),
    .code_plain (code_plain),
    .code_shift (code_shift),
    .code_alt   (code_alt),
    .code_ctrl  (code_ctrl),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  kpad_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  kpad_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .key_code    (key_code),
    .last_of_scan(last_of_scan)
  );

endmodule
`default_nettype wire

@@ sv/kpad_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module kpad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/kpad_front.sv @@
// Front end: accepts items and classifies them into queue commands.
`timescale 1ns / 1ps
`default_nettype none
module kpad_front import kpad_pkg::*; #(
  parameter int MATRIX_ROWS = 8,
  parameter int MATRIX_COLS = 8
) (
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        cmd,
  input  wire logic [4:0]  key_count,
  input  wire logic [2:0]  single_row,
  input  wire logic [2:0]  single_col,
  input  wire logic [63:0] pressed_map,
  input  wire logic [5:0]  entry_index,
  input  wire logic [7:0]  code_plain,
  input  wire logic [7:0]  code_shift,
  input  wire logic [7:0]  code_alt,
  input  wire logic [7:0]  code_ctrl,
  input  wire kpad_cfg_t   cfg,
  input  wire logic        q_full,
  output logic             q_push,
  output kpad_cmd_t        q_data
);

  function automatic logic [MAP_W-1:0] matrix_mask();
    logic [MAP_W-1:0] m;
    m = '0;
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) begin
        if (r < MATRIX_ROWS && c < MATRIX_COLS) begin
          m[c*8+r] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  localparam logic [MAP_W-1:0] MASK = matrix_mask();
  localparam logic [3:0] ROWS_L = 4'(MATRIX_ROWS);
  localparam logic [3:0] COLS_L = 4'(MATRIX_COLS);

  function automatic logic mod_hit(input logic [3:0] r, input logic [3:0] c,
                                   input logic [MAP_W-1:0] m);
    return (r < ROWS_L) && (c < COLS_L) && m[{c[2:0], r[2:0]}];
  endfunction

  function automatic logic [5:0] order_key(input logic [3:0] r, input logic [3:0] c);
    return {c[2:1], r[2:0], c[0]};
  endfunction

  logic [MAP_W-1:0] map_in;
  logic             sh_p, al_p, ct_p;
  logic [5:0]       sh_k, al_k, ct_k;
  logic             single_in, single_mod;
  kpad_set_t        multi_set;
  logic             keep;

  assign map_in = pressed_map & MASK;
  assign sh_p = mod_hit(cfg.shift_row, cfg.shift_col, map_in);
  assign al_p = mod_hit(cfg.alt_row, cfg.alt_col, map_in);
  assign ct_p = mod_hit(cfg.ctrl_row, cfg.ctrl_col, map_in);
  assign sh_k = order_key(cfg.shift_row, cfg.shift_col);
  assign al_k = order_key(cfg.alt_row, cfg.alt_col);
  assign ct_k = order_key(cfg.ctrl_row, cfg.ctrl_col);

  assign single_in = ({1'b0, single_row} < ROWS_L) && ({1'b0, single_col} < COLS_L);
  assign single_mod =
    (cfg.shift_row == {1'b0, single_row} && cfg.shift_col == {1'b0, single_col}) ||
    (cfg.alt_row == {1'b0, single_row} && cfg.alt_col == {1'b0, single_col}) ||
    (cfg.ctrl_row == {1'b0, single_row} && cfg.ctrl_col == {1'b0, single_col});

  // The earliest pressed modifier in walk order wins; shift wins a shared position, alt wins one shared with ctrl.
  always_comb begin
    if (sh_p && (!al_p || sh_k <= al_k) && (!ct_p || sh_k <= ct_k)) begin
      multi_set = SET_SHIFT;
    end else if (al_p && (!sh_p || al_k < sh_k) && (!ct_p || al_k <= ct_k)) begin
      multi_set = SET_ALT;
    end else if (ct_p && (!sh_p || ct_k < sh_k) && (!al_p || ct_k < al_k)) begin
      multi_set = SET_CTRL;
    end else begin
      multi_set = SET_PLAIN;
    end
  end

  always_comb begin
    keep = 1'b1;
    q_data.kind = CMD_SCAN;
    q_data.set = SET_PLAIN;
    q_data.map = map_in;
    q_data.index = entry_index;
    q_data.data = {code_ctrl, code_alt, code_shift, code_plain};
    if (!cmd) begin
      q_data.kind = CMD_LOAD;
    end else if (key_count == 5'd0) begin
      q_data.kind = CMD_CLEAR;
    end else if (key_count == 5'd1) begin
      q_data.map = MAP_W'(1) << {single_col, single_row};
      if (!single_in) begin
        keep = 1'b0;
      end else if (single_mod) begin
        q_data.kind = CMD_CLEAR;
      end
    end else begin
      q_data.set = multi_set;
    end
  end

  assign item_stall = q_full;
  assign q_push = item_valid && !q_full && keep;

endmodule
`default_nettype wire

@@ sv/kpad_fifo.sv @@
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module kpad_fifo import kpad_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire kpad_cmd_t push_data,
  output logic           full,
  input  wire logic      pop,
  output kpad_cmd_t      pop_data,
  output logic           empty
);

  localparam logic [1:0] SLOTS = 2'd2;

  kpad_cmd_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == SLOTS);
  assign empty = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/kpad_back.sv @@
// Back end: keymap storage, matrix walk, autorepeat and output register.
`timescale 1ns / 1ps
`default_nettype none
module kpad_back import kpad_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire kpad_cfg_t cfg,
  input  wire logic      q_empty,
  input  wire kpad_cmd_t q_data,
  output logic           q_pop,
  output logic           key_valid,
  input  wire logic      key_stall,
  output logic [7:0]     key_code,
  output logic           last_of_scan
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t                  state;
  logic [5:0]              pos;
  logic                    walk_done;
  logic                    s1_valid;
  logic                    s1_pressed;
  logic [MAP_W-1:0]        cur_map;
  kpad_set_t               cur_set;
  logic [CODE_W-1:0]       prev_key;
  logic [CNT_W-1:0]        rep_cnt;
  logic                    pend_valid;
  logic [CODE_W-1:0]       pend_code;
  logic [KEYMAP_DEPTH-1:0] ent_valid;
  logic                    ent_ok;

  logic                    can_push;
  logic                    adv;
  logic [2:0]              walk_row;
  logic [2:0]              walk_col;
  logic [5:0]              walk_addr;
  logic                    walk_bit;
  logic                    issue;
  logic                    ram_we;
  logic [ENTRY_W-1:0]      rdata;
  logic [ENTRY_W-1:0]      entry;
  logic [CODE_W-1:0]       code;
  logic                    look;
  logic                    is_new;
  logic                    rep_hold;
  logic                    emit;
  logic [CNT_W-1:0]        reload;
  logic                    out_load;

  assign can_push = !key_valid || !key_stall;
  assign adv = !(pend_valid && !can_push);
  assign walk_row = pos[3:1];
  assign walk_col = {pos[5:4], pos[0]};
  assign walk_addr = {walk_row, walk_col};
  assign walk_bit = cur_map[{walk_col, walk_row}];
  assign issue = (state == S_WALK) && !walk_done && adv;
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign ram_we = q_pop && (q_data.kind == CMD_LOAD);

  kpad_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(KEYMAP_DEPTH)
  ) u_keymap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_data.index),
    .wdata(q_data.data),
    .re   (issue),
    .raddr(walk_addr),
    .rdata(rdata)
  );

  assign entry = ent_ok ? rdata : '1;

  always_comb begin
    case (cur_set)
      SET_PLAIN: code = entry[7:0];
      SET_SHIFT: code = entry[15:8];
      SET_ALT:   code = entry[23:16];
      SET_CTRL:  code = entry[31:24];
      default:   code = NO_CODE;
    endcase
  end

  assign look = (state == S_WALK) && adv && s1_valid && s1_pressed && (code != NO_CODE);
  assign is_new = (code != prev_key);
  assign rep_hold = (rep_cnt < cfg.repeat_first);
  assign emit = look && (is_new || !rep_hold);
  assign reload = (cfg.repeat_first > cfg.repeat_next) ?
                  cfg.repeat_first - cfg.repeat_next : '0;
  assign out_load = (emit && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && can_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      walk_done <= 1'b0;
      s1_valid <= 1'b0;
      pend_valid <= 1'b0;
      key_valid <= 1'b0;
      prev_key <= NO_CODE;
      rep_cnt <= '0;
      ent_valid <= '0;
    end else begin
      if (out_load) begin
        key_valid <= 1'b1;
      end else if (!key_stall) begin
        key_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            case (q_data.kind)
              CMD_LOAD: begin
                ent_valid[q_data.index] <= 1'b1;
              end
              CMD_CLEAR: begin
                prev_key <= NO_CODE;
                rep_cnt <= '0;
              end
              CMD_SCAN: begin
                cur_map <= q_data.map;
                cur_set <= q_data.set;
                pos <= '0;
                walk_done <= 1'b0;
                s1_valid <= 1'b0;
                state <= S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (adv) begin
            if (!walk_done) begin
              s1_valid <= 1'b1;
              s1_pressed <= walk_bit;
              ent_ok <= ent_valid[walk_addr];
              pos <= pos + 6'd1;
              if (&pos) begin
                walk_done <= 1'b1;
              end
            end else begin
              s1_valid <= 1'b0;
            end
            if (look) begin
              if (is_new) begin
                prev_key <= code;
                rep_cnt <= '0;
              end else if (rep_hold) begin
                rep_cnt <= rep_cnt + CNT_W'(1);
              end else begin
                rep_cnt <= reload;
              end
            end
            if (emit) begin
              pend_code <= code;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                key_code <= pend_code;
                last_of_scan <= 1'b0;
              end
            end
            if (walk_done && !s1_valid) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (can_push) begin
            key_code <= pend_code;
            last_of_scan <= 1'b1;
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_empty_code: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key_code != NO_CODE)
    else $error("emitted item carries the no-code value");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending code left over outside a scan");

  a_stage_in_walk: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> state == S_WALK)
    else $error("lookup stage busy outside the matrix walk");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit && pend_valid |-> can_push)
    else $error("code emitted while the output register is blocked");
`endif

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the keypad scan to key code unit with autorepeat.
`timescale 1ns / 1ps
module tb_top import kpad_pkg::*; ();

  localparam int MATRIX_ROWS = 8;
  localparam int MATRIX_COLS = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 400;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef struct {
    logic        cmd;
    logic [4:0]  cnt;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] map;
    logic [5:0]  idx;
    logic [7:0]  plain;
    logic [7:0]  shifted;
    logic [7:0]  alted;
    logic [7:0]  ctrled;
  } kpad_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } key_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        cmd = 1'b0;
  logic [4:0]  key_count = '0;
  logic [2:0]  single_row = '0;
  logic [2:0]  single_col = '0;
  logic [63:0] pressed_map = '0;
  logic [5:0]  entry_index = '0;
  logic [7:0]  code_plain = '0;
  logic [7:0]  code_shift = '0;
  logic [7:0]  code_alt = '0;
  logic [7:0]  code_ctrl = '0;
  logic        key_valid;
  logic        key_stall = 1'b0;
  logic [7:0]  key_code;
  logic        last_of_scan;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  keypad_scan_to_keycode_autorepeat_unit #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .MATRIX_COLS(MATRIX_COLS)
  ) uut (.*);

  kpad_item_t  pending_q[$];
  key_exp_t    key_exp_q[$];
  logic [31:0] keymap_mirror [64] = '{default: '1};
  logic [7:0]  last_code = NO_CODE;
  logic [6:0]  hold_cnt = '0;
  kpad_cfg_t   cur_cfg = '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 7'd12, 7'd2};

  int   items_queued = 0;
  int   items_taken = 0;
  int   scans_done = 0;
  int   loads_done = 0;
  int   codes_seen = 0;
  int   settings_used = 0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;
  logic item_taken_d = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] key_bit(int pos);
    return 64'd1 << ((pos % 8) * 8 + pos / 8);
  endfunction

  function automatic kpad_set_t modifier_at(int row, int col);
    if (cur_cfg.shift_row == row && cur_cfg.shift_col == col) return SET_SHIFT;
    if (cur_cfg.alt_row == row && cur_cfg.alt_col == col) return SET_ALT;
    if (cur_cfg.ctrl_row == row && cur_cfg.ctrl_col == col) return SET_CTRL;
    return SET_PLAIN;
  endfunction

  function automatic void clear_repeat();
    last_code = NO_CODE;
    hold_cnt = '0;
  endfunction

  // Returns the code that the key emits, or NO_CODE when it emits nothing.
  function automatic logic [7:0] translate_key(int row, int col, kpad_set_t sel);
    logic [31:0] entry;
    logic [7:0]  code;
    entry = keymap_mirror[row * 8 + col];
    code = entry[int'(sel) * 8 +: 8];
    if (code == NO_CODE) return NO_CODE;
    if (code != last_code) begin
      last_code = code;
      hold_cnt = '0;
      return code;
    end
    if (hold_cnt < cur_cfg.repeat_first) begin
      hold_cnt = hold_cnt + 7'd1;
      return NO_CODE;
    end
    hold_cnt = (cur_cfg.repeat_first > cur_cfg.repeat_next) ?
               cur_cfg.repeat_first - cur_cfg.repeat_next : '0;
    return code;
  endfunction

  function automatic void predict_codes(kpad_item_t it);
    logic [7:0] codes[$];
    logic [7:0] code;
    kpad_set_t  sel;
    int         col;
    if (it.cmd == OP_LOAD) begin
      keymap_mirror[it.idx] = {it.ctrled, it.alted, it.shifted, it.plain};
      loads_done++;
      return;
    end
    scans_done++;
    if (it.cnt == 0) begin
      clear_repeat();
    end else if (it.cnt == 1) begin
      if (it.row < MATRIX_ROWS && it.col < MATRIX_COLS) begin
        if (modifier_at(it.row, it.col) != SET_PLAIN) begin
          clear_repeat();
        end else begin
          code = translate_key(it.row, it.col, SET_PLAIN);
          if (code != NO_CODE) codes.push_back(code);
        end
      end
    end else begin
      sel = SET_PLAIN;
      for (int pair = 0; pair < 4; pair++)
        for (int row = 0; row < 8; row++)
          for (int half = 0; half < 2; half++) begin
            col = pair * 2 + half;
            if (sel == SET_PLAIN && row < MATRIX_ROWS && col < MATRIX_COLS &&
                it.map[col * 8 + row])
              sel = modifier_at(row, col);
          end
      for (int pair = 0; pair < 4; pair++)
        for (int row = 0; row < 8; row++)
          for (int half = 0; half < 2; half++) begin
            col = pair * 2 + half;
            if (row < MATRIX_ROWS && col < MATRIX_COLS && it.map[col * 8 + row]) begin
              code = translate_key(row, col, sel);
              if (code != NO_CODE) codes.push_back(code);
            end
          end
    end
    foreach (codes[i]) key_exp_q.push_back('{code: codes[i], last: (i == codes.size() - 1)});
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Input driver: one item at a time from the pending queue, with random gaps.
  always @(negedge clk) begin
    kpad_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken_d) begin
      if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        item_valid <= 1'b1;
        cmd <= nxt.cmd;
        key_count <= nxt.cnt;
        single_row <= nxt.row;
        single_col <= nxt.col;
        pressed_map <= nxt.map;
        entry_index <= nxt.idx;
        code_plain <= nxt.plain;
        code_shift <= nxt.shifted;
        code_alt <= nxt.alted;
        code_ctrl <= nxt.ctrled;
        if ($urandom_range(0, 29) == 0) send_burst <= !send_burst;
        send_gap <= send_burst ? 0 : pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Output side stall pattern.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      key_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      if ($urandom_range(0, 49) == 0) recv_burst <= !recv_burst;
      if (!recv_burst && $urandom_range(0, 3) == 0) begin
        key_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        key_stall <= 1'b0;
      end
    end
  end

  // Monitor, predictor hookup and watchdog.
  always @(posedge clk) begin
    key_exp_t   want;
    kpad_item_t got;
    if (rst) begin
      item_taken_d <= 1'b0;
    end else begin
      item_taken_d <= item_valid && !item_stall;
      if (key_valid && !key_stall) begin
        codes_seen++;
        if (key_exp_q.size() == 0) begin
          note_error($sformatf("unexpected key code %02h last=%0b", key_code, last_of_scan));
        end else begin
          want = key_exp_q.pop_front();
          if (key_code !== want.code || last_of_scan !== want.last)
            note_error($sformatf("key code %02h last=%0b, expected %02h last=%0b",
                                 key_code, last_of_scan, want.code, want.last));
        end
      end
      if (item_valid && !item_stall) begin
        got = '{cmd, key_count, single_row, single_col, pressed_map, entry_index,
                code_plain, code_shift, code_alt, code_ctrl};
        predict_codes(got);
        items_taken++;
      end
      if ((item_valid && !item_stall) || (key_valid && !key_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Watchdog expired after %0d cycles without progress.", STALL_LIMIT);
          $display("** keypad_scan_to_keycode_autorepeat_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(kpad_reg_t r, logic [6:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_SHIFT_ROW:    cur_cfg.shift_row = d[3:0];
      REG_SHIFT_COL:    cur_cfg.shift_col = d[3:0];
      REG_ALT_ROW:      cur_cfg.alt_row = d[3:0];
      REG_ALT_COL:      cur_cfg.alt_col = d[3:0];
      REG_CTRL_ROW:     cur_cfg.ctrl_row = d[3:0];
      REG_CTRL_COL:     cur_cfg.ctrl_col = d[3:0];
      REG_REPEAT_FIRST: cur_cfg.repeat_first = d;
      REG_REPEAT_NEXT:  cur_cfg.repeat_next = d;
      default: ;
    endcase
  endtask

  task automatic set_config(int sr, int sc, int ar, int ac, int cr, int cc,
                            int first, int next_gap);
    write_reg(REG_SHIFT_ROW, 7'(sr));
    write_reg(REG_SHIFT_COL, 7'(sc));
    write_reg(REG_ALT_ROW, 7'(ar));
    write_reg(REG_ALT_COL, 7'(ac));
    write_reg(REG_CTRL_ROW, 7'(cr));
    write_reg(REG_CTRL_COL, 7'(cc));
    write_reg(REG_REPEAT_FIRST, 7'(first));
    write_reg(REG_REPEAT_NEXT, 7'(next_gap));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_item(kpad_item_t it);
    pending_q.push_back(it);
    items_queued++;
  endtask

  function automatic kpad_item_t junk_item();
    kpad_item_t it;
    it.cmd = OP_SCAN;
    it.cnt = 5'($urandom_range(0, 31));
    it.row = 3'($urandom_range(0, 7));
    it.col = 3'($urandom_range(0, 7));
    it.map = {$urandom, $urandom};
    it.idx = 6'($urandom_range(0, 63));
    it.plain = 8'($urandom_range(0, 255));
    it.shifted = 8'($urandom_range(0, 255));
    it.alted = 8'($urandom_range(0, 255));
    it.ctrled = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic load_entry(int idx, logic [7:0] p, logic [7:0] s, logic [7:0] a,
                            logic [7:0] c);
    kpad_item_t it;
    it = junk_item();
    it.cmd = OP_LOAD;
    it.idx = 6'(idx);
    it.plain = p;
    it.shifted = s;
    it.alted = a;
    it.ctrled = c;
    queue_item(it);
  endtask

  task automatic scan(int cnt, int row, int col, logic [63:0] map);
    kpad_item_t it;
    it = junk_item();
    it.cnt = 5'(cnt);
    it.row = 3'(row);
    it.col = 3'(col);
    it.map = map;
    queue_item(it);
  endtask

  function automatic logic [7:0] rnd_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return NO_CODE;
    if (r < 55) return 8'(8'h40 + $urandom_range(0, 7));
    return 8'($urandom_range(0, 254));
  endfunction

  // Random scans mostly hold a few hot keys so that autorepeat gets exercised.
  task automatic random_phase(int n);
    kpad_item_t it;
    int hot[6];
    int mods[$];
    int made;
    int pick;
    int run;
    int nk;
    int pos;
    made = 0;
    if (cur_cfg.shift_row < 8 && cur_cfg.shift_col < 8)
      mods.push_back(cur_cfg.shift_row * 8 + cur_cfg.shift_col);
    if (cur_cfg.alt_row < 8 && cur_cfg.alt_col < 8)
      mods.push_back(cur_cfg.alt_row * 8 + cur_cfg.alt_col);
    if (cur_cfg.ctrl_row < 8 && cur_cfg.ctrl_col < 8)
      mods.push_back(cur_cfg.ctrl_row * 8 + cur_cfg.ctrl_col);
    foreach (hot[i]) begin
      hot[i] = $urandom_range(0, 63);
      load_entry(hot[i], rnd_code(), rnd_code(), rnd_code(), rnd_code());
      made++;
    end
    foreach (mods[i]) begin
      load_entry(mods[i], rnd_code(), rnd_code(), rnd_code(), rnd_code());
      made++;
    end
    while (made < n) begin
      it = junk_item();
      pick = $urandom_range(0, 99);
      run = 1;
      if (pick < 12) begin
        it.cmd = OP_LOAD;
        if ($urandom_range(0, 1) == 0) it.idx = 6'(hot[$urandom_range(0, 5)]);
        it.plain = rnd_code();
        it.shifted = rnd_code();
        it.alted = rnd_code();
        it.ctrled = rnd_code();
      end else if (pick < 20) begin
        it.cnt = 5'd0;
      end else if (pick < 50) begin
        pos = $urandom_range(0, 63);
        if ($urandom_range(0, 9) < 6) pos = hot[$urandom_range(0, 5)];
        else if (mods.size() != 0 && $urandom_range(0, 1) == 0)
          pos = mods[$urandom_range(0, mods.size() - 1)];
        it.cnt = 5'd1;
        it.row = 3'(pos / 8);
        it.col = 3'(pos % 8);
        run = $urandom_range(1, 14);
      end else if (pick < 92) begin
        it.cnt = 5'($urandom_range(2, 31));
        it.map = '0;
        nk = $urandom_range(1, 4);
        repeat (nk) it.map |= key_bit(hot[$urandom_range(0, 5)]);
        if (mods.size() != 0 && $urandom_range(0, 2) == 0)
          it.map |= key_bit(mods[$urandom_range(0, mods.size() - 1)]);
        run = $urandom_range(1, 14);
      end else if (pick < 96) begin
        it.cnt = 5'($urandom_range(2, 31));
      end else begin
        it.cnt = 5'($urandom_range(2, 31));
        it.map = '0;
      end
      if (run > n - made) run = n - made;
      repeat (run) queue_item(it);
      made += run;
    end
  endtask

  task automatic drain();
    while (items_taken != items_queued || key_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] kbit(int row, int col);
    return 64'd1 << (col * 8 + row);
  endfunction

  initial begin
    int r;
    int c;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Shift at row 1 column 0, alt at row 6 column 7, ctrl at row 3 column 2.
    set_config(1, 0, 6, 7, 3, 2, 3, 1);
    load_entry(0, 8'h00, 8'h01, 8'h02, 8'h03);
    load_entry(63, 8'hFE, 8'hFD, 8'hFC, 8'hFB);
    load_entry(8, 8'h10, 8'h11, 8'h12, 8'h13);
    load_entry(55, 8'h20, 8'h21, 8'h22, 8'h23);
    load_entry(26, 8'h30, 8'h31, 8'h32, 8'h33);
    load_entry(9, NO_CODE, 8'h41, NO_CODE, 8'h43);
    scan(0, 0, 0, '0);
    repeat (5) scan(1, 0, 0, '0);
    scan(1, 1, 0, '0);
    scan(1, 1, 1, '0);
    scan(2, 0, 0, kbit(0, 0) | kbit(7, 7));
    scan(3, 0, 0, kbit(0, 0) | kbit(1, 0) | kbit(7, 7));
    scan(2, 0, 0, kbit(1, 1) | kbit(6, 7));
    scan(3, 0, 0, kbit(0, 0) | kbit(1, 0) | kbit(3, 2));
    scan(31, 0, 0, '1);
    scan(2, 0, 0, '0);
    scan(0, 0, 0, '1);
    scan(1, 7, 7, {$urandom, $urandom});
    scan(16, 0, 0, kbit(7, 7));
    drain();

    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: set_config($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                      0, 0);
        2: set_config(15, 15, 15, 15, 15, 15, 127, 127);
        3: begin
          r = $urandom_range(0, 7);
          c = $urandom_range(0, 7);
          set_config(r, c, r, c, $urandom_range(0, 7), $urandom_range(0, 7), 5, 127);
        end
        default: set_config($urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15));
      endcase
      random_phase(47);
      drain();
    end

    $display("Covered %0d scans and %0d keymap loads under %0d register settings.",
             scans_done, loads_done, settings_used);
    $display("Checked %0d key codes; %0d mismatches found.", codes_seen, errors);
    if (errors == 0 && key_exp_q.size() == 0) begin
      $display("** keypad_scan_to_keycode_autorepeat_unit: PASSED **");
    end else begin
      $display("** keypad_scan_to_keycode_autorepeat_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/kpad_pkg.sv
sv/kpad_ram.sv
sv/kpad_front.sv
sv/kpad_fifo.sv
sv/kpad_back.sv
sv/keypad_scan_to_keycode_autorepeat_unit.sv
verif/tb_top.sv
